// File: rtl/core/lapy_pkg.sv
`default_nettype none

package lapy_pkg;

  // Field widths fixed by the interface
  localparam int FIELD_W = 32;
  localparam int PITCH_W = 14;
  localparam int YAW_W   = 16;
  localparam int HOLD_W  = 16;

  // CORDIC datapath: magnitudes are scaled to Q.58, x/y stay below 2^61
  localparam int MW        = 59;
  localparam int DW        = 62;
  localparam int ZW        = 32;
  localparam int ANG_W     = 13;
  localparam int MAG_TOP   = 58;
  localparam int TABLE_LEN = 24;
  localparam int TIDX_W    = 5;

  // 1/K in Q0.30, applied to the horizontal length in two halves
  localparam int GAIN_FRAC = 30;
  localparam int MUL_AW    = DW - GAIN_FRAC;
  localparam logic [GAIN_FRAC-1:0] INV_GAIN = 30'd652032874;

  // Angles in Q4.12
  localparam logic [ANG_W-1:0]        HALF_PI = 13'd6434;
  localparam logic signed [YAW_W-1:0] YAW_PI  = 16'sd12868;

  typedef struct packed {
    logic signed [FIELD_W-1:0] origin_x;
    logic signed [FIELD_W-1:0] origin_y;
    logic signed [FIELD_W-1:0] origin_z;
    logic signed [FIELD_W-1:0] target_x;
    logic signed [FIELD_W-1:0] target_y;
    logic signed [FIELD_W-1:0] target_z;
  } item_t;

  typedef struct packed {
    logic signed [PITCH_W-1:0] pitch_angle;
    logic signed [YAW_W-1:0]   yaw_angle;
    logic                      updated;
  } result_t;

  // Request into the CORDIC unit
  typedef struct packed {
    logic                 start;
    logic signed [DW-1:0] x0;
    logic signed [DW-1:0] y0;
  } cord_req_t;

  // Status back from the CORDIC unit
  typedef struct packed {
    logic             done;
    logic [ANG_W-1:0] angle;
    logic [DW-1:0]    len;
  } cord_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_HORIZ,
    ST_HWAIT,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_MUL_SUM,
    ST_PSTART,
    ST_PWAIT,
    ST_DONE
  } state_t;

  // atan(2^-i) in Q2.28
  function automatic logic signed [ZW-1:0] atan_q28(input logic [TIDX_W-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 32'sd210828714;
      5'd1:    v = 32'sd124459457;
      5'd2:    v = 32'sd65760959;
      5'd3:    v = 32'sd33381290;
      5'd4:    v = 32'sd16755422;
      5'd5:    v = 32'sd8385879;
      5'd6:    v = 32'sd4193963;
      5'd7:    v = 32'sd2097109;
      5'd8:    v = 32'sd1048571;
      5'd9:    v = 32'sd524287;
      5'd10:   v = 32'sd262144;
      5'd11:   v = 32'sd131072;
      5'd12:   v = 32'sd65536;
      5'd13:   v = 32'sd32768;
      5'd14:   v = 32'sd16384;
      5'd15:   v = 32'sd8192;
      5'd16:   v = 32'sd4096;
      5'd17:   v = 32'sd2048;
      5'd18:   v = 32'sd1024;
      5'd19:   v = 32'sd512;
      5'd20:   v = 32'sd256;
      5'd21:   v = 32'sd128;
      5'd22:   v = 32'sd64;
      5'd23:   v = 32'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/look_at_pitch_yaw.sv
// Look-at orientation: turns an object position and a look-at point into
// pitch and yaw angles (radians, pitch in Q2.12 and yaw in Q4.12) and holds them as the current rotation.
//
// Channels: item/item_valid/item_ready carries one position and target beat
// (six signed Q16.16 coordinates); result/result_valid/result_ready returns
// one beat per item with pitch_angle, yaw_angle and updated.
//
// Sequence: when x and z of the offset are both nonzero the horizontal
// CORDIC pass runs, then, if y is nonzero, the 1/K multiply, then the pitch
// pass; each pass is skipped when not needed, and both when target equals
// position. One item is in work at a time: the single shared CORDIC unit,
// run once for the horizontal plane and once for pitch, does not take a new
// item until the last one is finished. item_ready is high only while the
// sequencer is idle.
//
// The result sits in an output register, so a stalled receiver holds the
// finished beat while the next item is already taken and computed; the
// sequencer waits at its last step only if a second result would overwrite
// one not yet taken. Synchronous reset clears the held angles to zero and
// drops result_valid.

`default_nettype none

module look_at_pitch_yaw
  import lapy_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_BITS   = 32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  localparam int CB    = COORD_BITS;
  localparam int OW    = CB + 1;
  localparam int SCALE = MAG_TOP - CB;

  // Low CB bits of a field as a signed coordinate (zero fill above 32)
  function automatic logic signed [CB-1:0] coord_in(input logic [FIELD_W-1:0] f);
    logic [CB+FIELD_W-1:0] wide;
    wide = {{CB{1'b0}}, f};
    return $signed(wide[CB-1:0]);
  endfunction

  function automatic logic signed [OW-1:0] offset(input logic [FIELD_W-1:0] a,
                                                  input logic [FIELD_W-1:0] b);
    logic signed [CB-1:0] ca, cb;
    ca = coord_in(a);
    cb = coord_in(b);
    return {ca[CB-1], ca} - {cb[CB-1], cb};
  endfunction

  function automatic logic [MW-1:0] mag_scaled(input logic signed [OW-1:0] d);
    logic [OW-1:0] m;
    m = d[OW-1] ? -d : d;
    return MW'(m) << SCALE;
  endfunction

  state_t state, state_next;

  logic signed [OW-1:0]     dx, dy, dz;
  logic [MW-1:0]            ax, ay, az;
  logic [DW-1:0]            hk, h, mul_p;
  logic [ANG_W-1:0]         pmag, ymag;
  logic signed [HOLD_W-1:0] held_pitch, held_yaw;

  logic                     dxnz, dynz, dznz, zero, both, pitch_run, out_load;
  logic [MUL_AW-1:0]        mul_a;
  logic [DW-1:0]            prod;
  cord_req_t                creq;
  cord_res_t                cres;
  logic signed [YAW_W-1:0]  yaw_a, yaw_val;
  logic signed [PITCH_W-1:0] pitch_val;

  // Offset flags
  assign dxnz = |dx;
  assign dynz = |dy;
  assign dznz = |dz;
  assign zero = !dxnz && !dynz && !dznz;
  assign both = dxnz && dznz;

  // Pitch pass runs unless dy is zero or the horizontal length is zero
  assign pitch_run = dynz && (dxnz || dznz) && !(both && (h == '0));
  assign out_load  = (state == ST_DONE) && (!result_valid || result_ready);

  lapy_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .res (cres)
  );

  // Shared 1/K multiplier, high half then low half of the length
  assign mul_a = (state == ST_MUL_HI) ? hk[DW-1:GAIN_FRAC] : MUL_AW'(hk[GAIN_FRAC-1:0]);
  assign prod  = DW'(mul_a) * DW'(INV_GAIN);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (item_valid) state_next = ST_PREP;
      ST_PREP: begin
        if (zero) state_next = ST_DONE;
        else if (both) state_next = ST_HORIZ;
        else state_next = ST_PSTART;
      end
      ST_HORIZ:   state_next = ST_HWAIT;
      ST_HWAIT:   if (cres.done) state_next = dynz ? ST_MUL_HI : ST_DONE;
      ST_MUL_HI:  state_next = ST_MUL_LO;
      ST_MUL_LO:  state_next = ST_MUL_SUM;
      ST_MUL_SUM: state_next = ST_PSTART;
      ST_PSTART:  state_next = pitch_run ? ST_PWAIT : ST_DONE;
      ST_PWAIT:   if (cres.done) state_next = ST_DONE;
      ST_DONE:    if (out_load) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    item_ready = 1'b0;
    creq.start = 1'b0;
    creq.x0    = DW'(az);
    creq.y0    = DW'(ax);
    case (state)
      ST_IDLE:   item_ready = 1'b1;
      ST_HORIZ:  creq.start = 1'b1;
      ST_PSTART: begin
        creq.start = pitch_run;
        creq.x0    = both ? h : DW'(ax) + DW'(az);
        creq.y0    = DW'(ay);
      end
      default: ;
    endcase
  end

  // Final angles with signs and the pi offset
  always_comb begin
    if (!dxnz) yaw_a = '0;
    else if (!dznz) yaw_a = YAW_W'(HALF_PI);
    else yaw_a = YAW_W'(ymag);
    if (dxnz && ((dznz && (dx[OW-1] != dz[OW-1])) || (!dznz && dx[OW-1]))) begin
      yaw_val = -yaw_a;
    end else begin
      yaw_val = yaw_a;
    end
    if (dznz && !dz[OW-1]) yaw_val = yaw_val + YAW_PI;
    pitch_val = dy[OW-1] ? -PITCH_W'(pmag) : PITCH_W'(pmag);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      held_pitch   <= '0;
      held_yaw     <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        result_valid <= 1'b1;
        if (!zero) begin
          held_pitch <= HOLD_W'(pitch_val);
          held_yaw   <= yaw_val;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          dx <= offset(item.origin_x, item.target_x);
          dy <= offset(item.origin_y, item.target_y);
          dz <= offset(item.origin_z, item.target_z);
        end
      end
      ST_PREP: begin
        ax   <= mag_scaled(dx);
        ay   <= mag_scaled(dy);
        az   <= mag_scaled(dz);
        pmag <= '0;
        ymag <= '0;
      end
      ST_HWAIT: begin
        if (cres.done) begin
          ymag <= cres.angle;
          hk   <= cres.len;
        end
      end
      ST_MUL_HI:  mul_p <= prod;
      ST_MUL_LO: begin
        h     <= mul_p;
        mul_p <= prod;
      end
      ST_MUL_SUM: h <= h + (mul_p >> GAIN_FRAC);
      ST_PSTART:  if (!pitch_run) pmag <= dynz ? HALF_PI : '0;
      ST_PWAIT:   if (cres.done) pmag <= cres.angle;
      default: ;
    endcase
    if (out_load) begin
      if (zero) begin
        result.pitch_angle <= held_pitch[PITCH_W-1:0];
        result.yaw_angle   <= held_yaw;
        result.updated     <= 1'b0;
      end else begin
        result.pitch_angle <= pitch_val;
        result.yaw_angle   <= yaw_val;
        result.updated     <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> (state == ST_PREP))
    else $error("accepted beat did not start the sequencer");

  a_cordic_done_expected: assert property (@(posedge clk) disable iff (rst)
    cres.done |-> (state == ST_HWAIT || state == ST_PWAIT))
    else $error("CORDIC finished outside a wait step");

  a_held_matches_result: assert property (@(posedge clk) disable iff (rst)
    (out_load && !zero) |=> (held_pitch[PITCH_W-1:0] == result.pitch_angle &&
                             held_yaw == result.yaw_angle && result.updated))
    else $error("held rotation differs from the delivered beat");
`endif

endmodule

`default_nettype wire

// File: rtl/core/lapy_cordic.sv
`default_nettype none

module lapy_cordic
  import lapy_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cord_req_t req,
  output cord_res_t      res
);

  localparam int IW = $clog2(STEPS);
  localparam logic [IW-1:0] LAST = IW'(STEPS - 1);

  logic                 busy;
  logic                 done;
  logic [IW-1:0]        i;
  logic signed [DW-1:0] x;
  logic signed [DW-1:0] y;
  logic signed [ZW-1:0] z;

  logic signed [DW-1:0] xs, ys, x_next, y_next;
  logic signed [ZW-1:0] z_next, at, zr;

  // One micro-rotation per cycle, driving y toward zero
  always_comb begin
    xs = x >>> i;
    ys = y >>> i;
    at = atan_q28(TIDX_W'(i));
    if (!y[DW-1]) begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + at;
    end else begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - at;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        i    <= '0;
      end else if (busy) begin
        i <= i + 1'b1;
        if (i == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Vector registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      x <= req.x0;
      y <= req.y0;
      z <= '0;
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

  // Round Q2.28 to Q4.12 half up, clamp to 0..pi/2
  always_comb begin
    zr = (z + 32'sd32768) >>> 16;
    res.done = done;
    res.len  = x[DW-1] ? '0 : x;
    if (zr[ZW-1]) begin
      res.angle = '0;
    end else if (zr > $signed(ZW'(HALF_PI))) begin
      res.angle = HALF_PI;
    end else begin
      res.angle = zr[ANG_W-1:0];
    end
  end

endmodule

`default_nettype wire
